>>> sv/cisr_pkg.sv
// Shared types, character codes and helpers for the C identifier suffix rewriter.
// Used by cisr_lexer, cisr_emitter and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cisr_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_STRING = 3'd2,
    MODE_CHAR   = 3'd3,
    MODE_BLOCK  = 3'd4,
    MODE_LINE   = 3'd5
  } mode_t;

  // Item kinds carried in the slave-side tuser
  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_KEY  = 1'b1;

  // Configuration register indexes
  localparam logic REG_SUFFIX_BYTES  = 1'b0;
  localparam logic REG_SUFFIX_LENGTH = 1'b1;

  localparam logic [3:0] SUFFIX_MAX = 4'd8;

  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;

  // Result bytes caused by one text byte: optional held byte, optional
  // suffix, optional echoed byte, in that order.
  typedef struct packed {
    logic       pre_valid;
    logic [7:0] pre_byte;
    logic       add_suffix;
    logic       echo_valid;
    logic [7:0] echo_byte;
  } burst_t;

  function automatic logic is_word(input logic [7:0] b);
    is_word = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
              (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

endpackage

`default_nettype wire

>>> sv/cisr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module cisr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/cisr_lexer.sv
// Lexer state, keyword table memories and per-byte keyword compare.
// Depends on cisr_pkg and cisr_ram.
`timescale 1ns / 1ps
`default_nettype none

module cisr_lexer #(
  parameter int NUM_KEYS    = 16,
  parameter int MAX_KEY_LEN = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             text_valid,
  input  wire logic             key_valid,
  input  wire logic [7:0]       in_byte,
  input  wire logic [3:0]       key_slot,
  input  wire logic [4:0]       key_position,
  output logic                  clearing,
  output logic                  burst_valid,
  output cisr_pkg::burst_t      burst
);

  localparam int AW = $clog2(MAX_KEY_LEN);
  localparam int LW = $clog2(MAX_KEY_LEN + 1);

  cisr_pkg::mode_t      mode, mode_next;
  logic                 at_line_start, at_line_start_next;
  logic                 pend_slash, pend_slash_next;
  logic                 pend_star, pend_star_next;
  logic                 pend_escape, pend_escape_next;
  logic [LW-1:0]        ident_length, ident_length_next;
  logic                 ident_too_long, ident_too_long_next;
  logic [NUM_KEYS-1:0]  still_matching, still_matching_next;

  logic [AW-1:0]        clr_addr;
  logic [NUM_KEYS-1:0]  fwd_hit;
  logic [7:0]           fwd_byte;

  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [7:0]           wr_data;
  logic                 wr_pos_ok;
  logic [NUM_KEYS-1:0]  ram_we;
  logic [7:0]           ram_q [NUM_KEYS];
  logic [7:0]           row   [NUM_KEYS];
  logic [NUM_KEYS-1:0]  row_match;
  logic [NUM_KEYS-1:0]  end_ok;
  logic                 len_full;
  logic                 hit_end;
  logic                 als_eff;
  logic                 slash_done;
  logic                 word;

  // One memory per keyword, all read at the next identifier position
  assign wr_addr   = clearing ? clr_addr : AW'(key_position);
  assign wr_data   = clearing ? 8'h00 : in_byte;
  assign wr_pos_ok = 32'(key_position) < 32'(MAX_KEY_LEN);
  assign rd_addr   = ident_length_next[AW-1:0];

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    assign ram_we[k] = clearing ||
                       (key_valid && wr_pos_ok && (32'(key_slot) == 32'(k)));

    cisr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_KEY_LEN)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[k]),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (rd_addr),
      .rdata (ram_q[k])
    );

    // A write to the entry being read is missed by the registered read: forward it
    assign row[k]       = fwd_hit[k] ? fwd_byte : ram_q[k];
    assign row_match[k] = (row[k] == in_byte);
    assign end_ok[k]    = still_matching[k] && (len_full || (row[k] == 8'h00));
  end

  assign len_full = (ident_length == LW'(MAX_KEY_LEN));
  assign hit_end  = !ident_too_long && (|end_ok);
  assign word     = cisr_pkg::is_word(in_byte);

  always_comb begin
    mode_next           = mode;
    at_line_start_next  = at_line_start;
    pend_slash_next     = pend_slash;
    pend_star_next      = pend_star;
    pend_escape_next    = pend_escape;
    ident_length_next   = ident_length;
    ident_too_long_next = ident_too_long;
    still_matching_next = still_matching;
    burst               = '0;
    als_eff             = at_line_start;
    slash_done          = 1'b0;

    if (text_valid) begin
      case (mode)
        cisr_pkg::MODE_NORMAL: begin
          if (pend_slash) begin
            pend_slash_next = 1'b0;
            burst.pre_valid = 1'b1;
            burst.pre_byte  = cisr_pkg::CH_SLASH;
            if (in_byte == cisr_pkg::CH_STAR || in_byte == cisr_pkg::CH_SLASH) begin
              burst.echo_valid = 1'b1;
              burst.echo_byte  = in_byte;
              mode_next  = (in_byte == cisr_pkg::CH_STAR) ? cisr_pkg::MODE_BLOCK
                                                          : cisr_pkg::MODE_LINE;
              slash_done = 1'b1;
            end else begin
              als_eff            = 1'b0;
              at_line_start_next = 1'b0;
            end
          end
          if (!slash_done) begin
            if (word) begin
              ident_length_next   = LW'(1);
              ident_too_long_next = 1'b0;
              still_matching_next = row_match;
              mode_next           = cisr_pkg::MODE_IDENT;
              burst.echo_valid    = 1'b1;
              burst.echo_byte     = in_byte;
            end else if (in_byte == cisr_pkg::CH_SLASH) begin
              pend_slash_next = 1'b1;
            end else if (als_eff && in_byte == cisr_pkg::CH_HASH) begin
              burst.echo_valid = 1'b1;
              burst.echo_byte  = in_byte;
              mode_next        = cisr_pkg::MODE_LINE;
            end else begin
              burst.echo_valid = 1'b1;
              burst.echo_byte  = in_byte;
              if (in_byte == cisr_pkg::CH_NL) begin
                at_line_start_next = 1'b1;
              end else if (!cisr_pkg::is_space(in_byte)) begin
                at_line_start_next = 1'b0;
              end
              if (in_byte == cisr_pkg::CH_DQUOTE) begin
                mode_next = cisr_pkg::MODE_STRING;
              end else if (in_byte == cisr_pkg::CH_SQUOTE) begin
                mode_next = cisr_pkg::MODE_CHAR;
              end
            end
          end
        end

        cisr_pkg::MODE_IDENT: begin
          burst.echo_valid = 1'b1;
          burst.echo_byte  = in_byte;
          if (word) begin
            if (!len_full) begin
              still_matching_next = still_matching & row_match;
              ident_length_next   = ident_length + LW'(1);
            end else begin
              ident_too_long_next = 1'b1;
            end
          end else begin
            burst.add_suffix  = hit_end;
            ident_length_next = '0;
            if (in_byte == cisr_pkg::CH_DQUOTE) begin
              mode_next = cisr_pkg::MODE_STRING;
            end else if (in_byte == cisr_pkg::CH_SQUOTE) begin
              mode_next = cisr_pkg::MODE_CHAR;
            end else begin
              mode_next = cisr_pkg::MODE_NORMAL;
            end
          end
        end

        cisr_pkg::MODE_STRING, cisr_pkg::MODE_CHAR: begin
          burst.echo_valid = 1'b1;
          burst.echo_byte  = in_byte;
          if (pend_escape) begin
            pend_escape_next = 1'b0;
          end else if (in_byte == cisr_pkg::CH_BSLASH) begin
            pend_escape_next = 1'b1;
          end else if (in_byte == ((mode == cisr_pkg::MODE_STRING) ?
                                   cisr_pkg::CH_DQUOTE : cisr_pkg::CH_SQUOTE)) begin
            mode_next = cisr_pkg::MODE_NORMAL;
          end
        end

        cisr_pkg::MODE_BLOCK: begin
          if (pend_star) begin
            pend_star_next  = 1'b0;
            burst.pre_valid = 1'b1;
            burst.pre_byte  = cisr_pkg::CH_STAR;
          end
          if (pend_star && in_byte == cisr_pkg::CH_SLASH) begin
            burst.echo_valid = 1'b1;
            burst.echo_byte  = in_byte;
            mode_next        = cisr_pkg::MODE_NORMAL;
          end else if (in_byte == cisr_pkg::CH_STAR) begin
            pend_star_next = 1'b1;
          end else begin
            burst.echo_valid = 1'b1;
            burst.echo_byte  = in_byte;
          end
        end

        cisr_pkg::MODE_LINE: begin
          burst.echo_valid = 1'b1;
          burst.echo_byte  = in_byte;
          if (in_byte == cisr_pkg::CH_NL) begin
            mode_next = cisr_pkg::MODE_NORMAL;
          end
        end

        default: begin
          burst.echo_valid = 1'b1;
          burst.echo_byte  = in_byte;
          mode_next        = cisr_pkg::MODE_NORMAL;
        end
      endcase
    end
  end

  assign burst_valid = text_valid && (burst.pre_valid || burst.echo_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= cisr_pkg::MODE_NORMAL;
      at_line_start  <= 1'b1;
      pend_slash     <= 1'b0;
      pend_star      <= 1'b0;
      pend_escape    <= 1'b0;
      ident_length   <= '0;
      ident_too_long <= 1'b0;
      still_matching <= '1;
      clearing       <= 1'b1;
      clr_addr       <= '0;
      fwd_hit        <= '0;
    end else begin
      mode           <= mode_next;
      at_line_start  <= at_line_start_next;
      pend_slash     <= pend_slash_next;
      pend_star      <= pend_star_next;
      pend_escape    <= pend_escape_next;
      ident_length   <= ident_length_next;
      ident_too_long <= ident_too_long_next;
      still_matching <= still_matching_next;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(MAX_KEY_LEN - 1)) begin
          clearing <= 1'b0;
        end
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
        fwd_hit[k] <= ram_we[k] && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_byte <= wr_data;
  end

endmodule

`default_nettype wire

>>> sv/cisr_emitter.sv
// Two-entry queue of result bursts and the byte serializer that drains it.
// Depends on cisr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cisr_emitter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire cisr_pkg::burst_t  push_burst,
  input  wire logic [63:0]       suffix_bytes,
  input  wire logic [3:0]        suffix_length,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   from_suffix,
  output logic                   last
);

  cisr_pkg::burst_t fifo [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pre_sent;
  logic [3:0]       sfx_idx;

  cisr_pkg::burst_t head;
  logic [3:0]       sfx_len;
  logic             sel_pre;
  logic             sel_sfx;
  logic             xfer;
  logic             pop;

  assign head      = fifo[rd_ptr];
  assign sfx_len   = (suffix_length > cisr_pkg::SUFFIX_MAX) ? cisr_pkg::SUFFIX_MAX
                                                            : suffix_length;
  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);

  always_comb begin
    sel_pre = head.pre_valid && !pre_sent;
    sel_sfx = !sel_pre && head.add_suffix && (sfx_idx < sfx_len);
    if (sel_pre) begin
      out_byte = head.pre_byte;
      last     = !head.echo_valid;
    end else if (sel_sfx) begin
      out_byte = suffix_bytes[{sfx_idx[2:0], 3'b000} +: 8];
      last     = 1'b0;
    end else begin
      out_byte = head.echo_byte;
      last     = 1'b1;
    end
    from_suffix = sel_sfx;
  end

  assign xfer = out_valid && out_ready;
  assign pop  = xfer && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      count    <= 2'd0;
      pre_sent <= 1'b0;
      sfx_idx  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (xfer) begin
        if (pop) begin
          pre_sent <= 1'b0;
          sfx_idx  <= '0;
          rd_ptr   <= ~rd_ptr;
        end else if (sel_pre) begin
          pre_sent <= 1'b1;
        end else begin
          sfx_idx <= sfx_idx + 4'd1;
        end
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= push_burst;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("burst queue count out of range");

  assert property (@(posedge clk) disable iff (rst)
                   (count == 2'd2) |-> !push)
    else $error("burst pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && sel_sfx) |-> head.echo_valid)
    else $error("suffix burst without a terminating echo byte");

endmodule

`default_nettype wire

>>> sv/c_identifier_suffix_rewriter.sv
// Top level of the C identifier suffix rewriter: stream ports, configuration
// registers, lexer and result emitter. Depends on cisr_pkg, cisr_lexer,
// cisr_emitter (and through the lexer, cisr_ram).
//
// Usage:
//  - s_axis carries one item per transfer. tuser = 0: a text byte; tuser = 1:
//    one keyword table byte written at (key_slot, key_position), zero ends
//    the keyword. Table writes produce no output.
//  - m_axis carries the echoed text with the suffix inserted after every
//    identifier that equals a loaded keyword, just before the byte that ends
//    the identifier. tuser marks a suffix byte, tlast marks the final byte
//    caused by one input item.
//  - cfg_we/cfg_index/cfg_data write suffix_bytes (index 0) and
//    suffix_length (index 1); write only while idle.
//  - Throughput: one item per cycle while s_axis_tready is high. The keyword
//    table holds one memory per keyword, all read in the same cycle at the
//    next identifier position, so every comparison runs in parallel. An item
//    gives up to 9 result bytes, one per output transfer, which backs up the
//    two-entry burst queue and drops s_axis_tready.
//  - Output: the result bytes of an accepted item are registered as one
//    burst in the queue, and m_axis is driven from the queue head.
//  - Reset: after rst the keyword table is cleared one position per cycle,
//    all MAX_KEY_LEN positions, with s_axis_tready low. Config registers reset to 0.
//  - A stalled receiver holds m_axis steady; input stalls once the queue
//    holds two pending items.
`timescale 1ns / 1ps
`default_nettype none

module c_identifier_suffix_rewriter #(
  parameter int NUM_KEYS    = 16,
  parameter int MAX_KEY_LEN = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [7:0] in_byte, [11:8] key_slot,
                                          // [16:12] key_position, [23:17] zero
  input  wire logic        s_axis_tuser,  // [0] func

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic             m_axis_tuser,  // [0] from_suffix
  output logic             m_axis_tlast,  // last

  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0]      suffix_bytes;
  logic [3:0]       suffix_length;

  logic             in_xfer;
  logic             text_valid;
  logic             key_valid;
  logic             clearing;
  logic             space;
  logic             burst_valid;
  cisr_pkg::burst_t burst;

  // Hold input off while the table clears or the burst queue is full
  assign s_axis_tready = !clearing && space;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign text_valid    = in_xfer && (s_axis_tuser == cisr_pkg::FUNC_TEXT);
  assign key_valid     = in_xfer && (s_axis_tuser == cisr_pkg::FUNC_KEY);

  always_ff @(posedge clk) begin
    if (rst) begin
      suffix_bytes  <= '0;
      suffix_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cisr_pkg::REG_SUFFIX_BYTES:  suffix_bytes  <= cfg_data;
        cisr_pkg::REG_SUFFIX_LENGTH: suffix_length <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  cisr_lexer #(
    .NUM_KEYS    (NUM_KEYS),
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .key_valid    (key_valid),
    .in_byte      (s_axis_tdata[7:0]),
    .key_slot     (s_axis_tdata[11:8]),
    .key_position (s_axis_tdata[16:12]),
    .clearing     (clearing),
    .burst_valid  (burst_valid),
    .burst        (burst)
  );

  cisr_emitter u_emitter (
    .clk           (clk),
    .rst           (rst),
    .push          (burst_valid),
    .push_burst    (burst),
    .suffix_bytes  (suffix_bytes),
    .suffix_length (suffix_length),
    .space         (space),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (m_axis_tdata),
    .from_suffix   (m_axis_tuser),
    .last          (m_axis_tlast)
  );

  assert property (@(posedge clk) disable iff (rst) clearing |-> !s_axis_tready)
    else $error("input accepted during keyword table clear");

  assert property (@(posedge clk) disable iff (rst)
                   (m_axis_tvalid && m_axis_tuser) |-> !m_axis_tlast)
    else $error("suffix byte marked as final byte of an item");

  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

>>> verif/c_identifier_suffix_rewriter_test.sv
// Self-checking testbench for c_identifier_suffix_rewriter: streams keyword loads and
// C-like text, predicts every echoed and suffix byte, and compares them on m_axis.
// Depends on cisr_pkg and the c_identifier_suffix_rewriter RTL.
`timescale 1ns / 1ps

module c_identifier_suffix_rewriter_test;
  import cisr_pkg::*;

  localparam int KEYS    = 16;
  localparam int KEY_LEN = 32;

  // One slave-side transfer: a text byte or a keyword table write
  typedef struct packed {
    logic       func;
    logic [7:0] ch;
    logic [3:0] slot;
    logic [4:0] pos;
  } src_item_t;

  // One master-side transfer as the rewriter should produce it
  typedef struct packed {
    logic [7:0] ch;
    logic       from_sfx;
    logic       last;
  } out_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // [7:0] in_byte, [11:8] key_slot, [16:12] key_position
  logic        s_axis_tuser  = FUNC_TEXT;  // [0] func

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [7:0] out_byte
  logic        m_axis_tuser;       // [0] from_suffix
  logic        m_axis_tlast;

  logic        cfg_we    = 1'b0;
  logic        cfg_index = REG_SUFFIX_BYTES;
  logic [63:0] cfg_data  = '0;

  c_identifier_suffix_rewriter #(
    .NUM_KEYS   (KEYS),
    .MAX_KEY_LEN(KEY_LEN)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: lexer, identifier matcher, keyword table, suffix setting
  // ---------------------------------------------------------------------------
  mode_t       lex_mode    = MODE_NORMAL;
  logic        line_start  = 1'b1;
  logic        held_slash  = 1'b0;
  logic        held_star   = 1'b0;
  logic        esc_pending = 1'b0;
  int          id_len      = 0;
  logic        id_long     = 1'b0;
  logic [15:0] live_keys   = '1;
  logic [7:0]  key_mem [KEYS][KEY_LEN];
  logic [63:0] sfx_bytes   = '0;
  logic [3:0]  sfx_len     = '0;

  out_rec_t  burst[$];          // results of the item being predicted
  out_rec_t  rewritten[$];      // results still owed by the rewriter
  src_item_t pending_items[$];  // stimulus not yet offered on s_axis

  int mismatches  = 0;
  int text_count  = 0;
  int key_count   = 0;
  int bytes_seen  = 0;
  int suffix_seen = 0;
  int queued      = 0;

  function automatic logic word_byte(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || b == CH_UNDER;
  endfunction

  function automatic logic blank_byte(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic void put_out(input logic [7:0] b, input logic sfx);
    out_rec_t r;
    r.ch       = b;
    r.from_sfx = sfx;
    r.last     = 1'b0;
    burst.push_back(r);
  endfunction

  // Advance the keyword comparison by one identifier character
  function automatic void ident_step(input logic [7:0] b);
    if (id_len < KEY_LEN) begin
      for (int k = 0; k < KEYS; k++)
        if (key_mem[k][id_len] != b) live_keys[k] = 1'b0;
      id_len++;
    end else begin
      id_long = 1'b1;
    end
    put_out(b, 1'b0);
  endfunction

  // Identifier closed: emit the suffix once if any keyword still matches in full
  function automatic void ident_close();
    logic hit;
    int   n;
    hit = 1'b0;
    if (id_long) return;
    for (int k = 0; k < KEYS; k++) begin
      if (live_keys[k]) begin
        if (id_len >= KEY_LEN) hit = 1'b1;
        else if (key_mem[k][id_len] == 8'd0) hit = 1'b1;
      end
    end
    if (!hit) return;
    n = (sfx_len > SUFFIX_MAX) ? SUFFIX_MAX : sfx_len;
    for (int i = 0; i < n; i++) put_out(sfx_bytes[8*i +: 8], 1'b1);
  endfunction

  function automatic void normal_step(input logic [7:0] b);
    if (word_byte(b)) begin
      id_len    = 0;
      id_long   = 1'b0;
      live_keys = '1;
      lex_mode  = MODE_IDENT;
      ident_step(b);
      return;
    end
    if (b == CH_SLASH) begin
      held_slash = 1'b1;
      return;
    end
    if (line_start && b == CH_HASH) begin
      put_out(b, 1'b0);
      lex_mode = MODE_LINE;
      return;
    end
    put_out(b, 1'b0);
    if (!blank_byte(b)) line_start = 1'b0;
    if (b == CH_NL) line_start = 1'b1;
    if (b == CH_DQUOTE) lex_mode = MODE_STRING;
    if (b == CH_SQUOTE) lex_mode = MODE_CHAR;
  endfunction

  // Work out the output bytes for one accepted item and queue them
  function automatic void rewrite_byte(input src_item_t it);
    logic [7:0] b;
    logic       done;
    b    = it.ch;
    done = 1'b0;
    if (it.func == FUNC_KEY) begin
      key_mem[it.slot][it.pos] = b;
      key_count++;
      return;
    end
    text_count++;
    burst.delete();
    case (lex_mode)
      MODE_NORMAL: begin
        if (held_slash) begin
          held_slash = 1'b0;
          put_out(CH_SLASH, 1'b0);
          if (b == CH_STAR || b == CH_SLASH) begin
            put_out(b, 1'b0);
            lex_mode = (b == CH_STAR) ? MODE_BLOCK : MODE_LINE;
            done = 1'b1;
          end else begin
            line_start = 1'b0;
          end
        end
        if (!done) normal_step(b);
      end
      MODE_IDENT: begin
        if (word_byte(b)) begin
          ident_step(b);
        end else begin
          ident_close();
          put_out(b, 1'b0);
          lex_mode = (b == CH_DQUOTE) ? MODE_STRING :
                     (b == CH_SQUOTE) ? MODE_CHAR : MODE_NORMAL;
        end
      end
      MODE_STRING, MODE_CHAR: begin
        put_out(b, 1'b0);
        if (esc_pending) esc_pending = 1'b0;
        else if (b == CH_BSLASH) esc_pending = 1'b1;
        else if (b == ((lex_mode == MODE_STRING) ? CH_DQUOTE : CH_SQUOTE))
          lex_mode = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (held_star) begin
          held_star = 1'b0;
          put_out(CH_STAR, 1'b0);
          if (b == CH_SLASH) begin
            put_out(b, 1'b0);
            lex_mode = MODE_NORMAL;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (b == CH_STAR) held_star = 1'b1;
          else put_out(b, 1'b0);
        end
      end
      MODE_LINE: begin
        put_out(b, 1'b0);
        if (b == CH_NL) lex_mode = MODE_NORMAL;
      end
      default: begin
        lex_mode = MODE_NORMAL;
        put_out(b, 1'b0);
      end
    endcase
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) rewritten.push_back(burst[i]);
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < 40) $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued items, predict each one on its transfer
  // ---------------------------------------------------------------------------
  src_item_t in_flight = '0;
  int        gap_left  = 0;
  logic      s_calm    = 1'b0;

  always @(posedge clk) begin : driver
    src_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) rewrite_byte(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          // hold off before the next item
          s_axis_tvalid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          s_axis_tdata  <= {7'd0, nxt.pos, nxt.slot, nxt.ch};
          s_axis_tuser  <= nxt.func;
          s_axis_tvalid <= 1'b1;
          in_flight     <= nxt;
          gap_left      <= s_calm ? 0 : $urandom_range(0, 8);
          if ($urandom_range(0, 19) == 0) s_calm <= !s_calm;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each output transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  logic m_calm     = 1'b0;

  always @(posedge clk) begin : monitor
    out_rec_t want;
    int       hold;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_seen++;
        if (m_axis_tuser) suffix_seen++;
        if (rewritten.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h user %0b last %0b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = rewritten.pop_front();
          if (m_axis_tdata !== want.ch)
            flag_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, want.ch));
          if (m_axis_tuser !== want.from_sfx)
            flag_mismatch($sformatf("from_suffix %0b, want %0b (byte %02h)",
                                    m_axis_tuser, want.from_sfx, want.ch));
          if (m_axis_tlast !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                    m_axis_tlast, want.last, want.ch));
        end
      end
      if (m_axis_tready) begin
        // stall at random after a transfer, and now and then while nothing is offered
        if (m_axis_tvalid || $urandom_range(0, 7) == 0) begin
          hold = m_calm ? 0 : $urandom_range(0, 8);
          if (hold != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= hold - 1;
          end
          if ($urandom_range(0, 19) == 0) m_calm <= !m_calm;
        end
      end else if (stall_left == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------
  logic [7:0] kw_chars [KEYS][KEY_LEN];  // what the generator last loaded per slot
  int         kw_len   [KEYS];

  function automatic void push_item(input logic func, input logic [7:0] ch,
                                    input logic [3:0] slot, input logic [4:0] pos);
    src_item_t it;
    it.func = func;
    it.ch   = ch;
    it.slot = slot;
    it.pos  = pos;
    pending_items.push_back(it);
    queued++;
  endfunction

  function automatic void push_text(input logic [7:0] ch);
    push_item(FUNC_TEXT, ch, 4'd0, 5'd0);
  endfunction

  function automatic void push_key(input int slot, input int pos, input logic [7:0] ch);
    push_item(FUNC_KEY, ch, slot[3:0], pos[4:0]);
  endfunction

  function automatic void push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_text(s[i]);
  endfunction

  function automatic logic [7:0] any_word_char();
    case ($urandom_range(0, 5))
      0, 1:    return 8'(8'h61 + $urandom_range(0, 25));
      2:       return 8'(8'h41 + $urandom_range(0, 25));
      3:       return 8'(8'h30 + $urandom_range(0, 9));
      4:       return CH_UNDER;
      default: return 8'(8'h61 + $urandom_range(0, 3));  // short alphabet, more hits
    endcase
  endfunction

  function automatic logic [7:0] non_word_char();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0:       return " ";
      1:       return CH_NL;
      2:       return "(";
      3:       return ";";
      4:       return CH_SLASH;
      5:       return CH_DQUOTE;
      6:       return CH_SQUOTE;
      7:       return CH_STAR;
      8:       return CH_HASH;
      default: begin
        b = 8'($urandom_range(0, 255));
        while (word_byte(b)) b = 8'($urandom_range(0, 255));
        return b;
      end
    endcase
  endfunction

  function automatic void push_word(input int len);
    for (int i = 0; i < len; i++) push_text(any_word_char());
  endfunction

  // Load a fresh keyword into a slot; full-length words carry no terminator
  function automatic void load_keyword(input int slot, input int len);
    for (int i = 0; i < len; i++) begin
      kw_chars[slot][i] = any_word_char();
      push_key(slot, i, kw_chars[slot][i]);
    end
    if (len < KEY_LEN) push_key(slot, len, 8'd0);
    kw_len[slot] = len;
  endfunction

  function automatic void push_escape_or_plain(input logic [7:0] close_q);
    case ($urandom_range(0, 4))
      0: begin
        push_text(CH_BSLASH);
        case ($urandom_range(0, 3))
          0: push_text(CH_DQUOTE);
          1: push_text(CH_SQUOTE);
          2: push_text(CH_BSLASH);
          default: push_text("n");
        endcase
      end
      1: push_text(" ");
      2: push_text(close_q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
      default: push_text(any_word_char());
    endcase
  endfunction

  // One piece of C-like text, mostly well formed
  function automatic void push_token();
    int pick, slot, len;
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, KEYS - 1);
    len  = kw_len[slot];
    if (pick < 30) begin
      // identifier built from a loaded keyword: exact, longer, or a prefix
      case ($urandom_range(0, 4))
        0:       len = len + 1;
        1:       len = (len > 1) ? len - 1 : len;
        default: ;
      endcase
      if (len == 0) len = 1;
      for (int i = 0; i < len; i++)
        push_text(i < kw_len[slot] ? kw_chars[slot][i] : any_word_char());
      push_text(non_word_char());
    end else if (pick < 40) begin
      push_word($urandom_range(0, 7) == 0 ? $urandom_range(30, 36) : $urandom_range(1, 5));
      push_text(non_word_char());
    end else if (pick < 48) begin
      push_text(CH_DQUOTE);
      repeat ($urandom_range(0, 6)) push_escape_or_plain(CH_DQUOTE);
      push_text(CH_DQUOTE);
    end else if (pick < 52) begin
      push_text(CH_SQUOTE);
      push_escape_or_plain(CH_SQUOTE);
      push_text(CH_SQUOTE);
    end else if (pick < 58) begin
      push_text(CH_SLASH);
      push_text(CH_STAR);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 4))
          0:       push_text(CH_STAR);
          1:       push_text(CH_SLASH);
          2:       push_text(CH_NL);
          default: push_text(any_word_char());
        endcase
      end
      push_text(CH_STAR);
      push_text(CH_SLASH);
    end else if (pick < 63) begin
      push_text(CH_SLASH);
      push_text(CH_SLASH);
      push_word($urandom_range(0, 4));
      push_text(CH_NL);
    end else if (pick < 68) begin
      push_text(CH_NL);
      if ($urandom_range(0, 1) == 0) push_text(" ");
      push_text(CH_HASH);
      push_word($urandom_range(1, 5));
      push_text(" ");
      push_word($urandom_range(0, 3));
      push_text(CH_NL);
    end else if (pick < 78) begin
      push_text(non_word_char());
    end else if (pick < 84) begin
      // a division: the held slash is released by an ordinary byte
      push_text(" ");
      push_text(CH_SLASH);
      case ($urandom_range(0, 2))
        0:       push_text(" ");
        1:       push_text("=");
        default: push_text(any_word_char());
      endcase
    end else if (pick < 90) begin
      push_text(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      load_keyword(slot, $urandom_range(0, 5) == 0 ? KEY_LEN : $urandom_range(1, 6));
    end else if (pick < 98) begin
      // table write while an identifier is open
      if (len == 0) len = 1;
      push_text(len <= kw_len[slot] ? kw_chars[slot][0] : any_word_char());
      push_key($urandom_range(0, KEYS - 1), $urandom_range(0, KEY_LEN - 1),
               $urandom_range(0, 3) == 0 ? 8'd0 : any_word_char());
      for (int i = 1; i < len; i++)
        push_text(i < kw_len[slot] ? kw_chars[slot][i] : any_word_char());
      push_text(non_word_char());
    end else begin
      push_key($urandom_range(0, KEYS - 1), $urandom_range(0, KEY_LEN - 1),
               8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic write_reg(input logic idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_SUFFIX_BYTES) sfx_bytes = val;
    else sfx_len = val[3:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until everything offered has come back, then let held bytes settle
  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid || rewritten.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_suffix(input logic [63:0] chars, input logic [3:0] len);
    write_reg(REG_SUFFIX_BYTES, chars);
    write_reg(REG_SUFFIX_LENGTH, {$urandom, $urandom} & ~64'hF | 64'(len));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int phase_target;
    for (int k = 0; k < KEYS; k++) begin
      kw_len[k] = 0;
      for (int p = 0; p < KEY_LEN; p++) begin
        key_mem[k][p]  = 8'd0;
        kw_chars[k][p] = 8'd0;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: two-byte suffix "_f"
    set_suffix(64'h665F, 4'd2);
    // "if" twice in the table checks the suffix is not doubled
    push_key(0, 0, "i");
    push_key(0, 1, "f");
    push_key(0, 2, 8'd0);
    push_key(1, 0, "i");
    push_key(1, 1, "f");
    push_key(15, 31, 8'hFF);
    kw_chars[0][0] = "i";
    kw_chars[0][1] = "f";
    kw_len[0]      = 2;
    push_str("#if\n");         // directive at line start: no rewrite
    push_str("if/");           // match; the ending slash starts nothing
    push_str("\"if\\\"\"");    // string with an escaped quote
    push_str("'\\''");         // character literal with escape
    push_str("/*if**/");       // block comment with a held star
    push_str(" if//\n");       // slash after identifier, then held slash
    push_text(8'hFF);
    push_text(8'h00);
    drain();

    // Random phases over the suffix settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_suffix(64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        1:       set_suffix(64'h0, 4'd15);
        2:       set_suffix({$urandom, $urandom}, 4'd0);
        default: set_suffix({$urandom, $urandom}, 4'($urandom_range(1, 15)));
      endcase
      phase_target = queued + 78;
      while (queued < phase_target) push_token();
      drain();
    end

    $display("Sent %0d text bytes and %0d keyword table writes over 5 suffix settings.",
             text_count, key_count);
    $display("Checked %0d output bytes, %0d of them suffix bytes.", bytes_seen, suffix_seen);
    if (mismatches == 0 && rewritten.size() == 0) begin
      $display("PASS c_identifier_suffix_rewriter");
    end else begin
      $display("FAIL c_identifier_suffix_rewriter");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d bytes still owed.", rewritten.size());
    $display("FAIL c_identifier_suffix_rewriter");
    $finish;
  end

endmodule
